[hdl/stwc_pkg.sv]
// Shared types, codes and sizes for the stream time window counter.
// No dependencies; every other file of the block uses this package.
`timescale 1ns / 1ps
`default_nettype none
package stwc_pkg;

  localparam int STORE_DEPTH = 1024;
  localparam int TIME_BITS   = 47;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int CFG_W       = 40;
  localparam int WIN_W       = 48;
  // internal window bounds carry one guard bit above the output width
  localparam int CUR_W       = WIN_W + 1;
  localparam int DCNT_W      = $clog2(TIME_BITS);
  localparam int PADDR_W     = 5;
  localparam int PDATA_W     = 64;
  localparam logic [CFG_W-1:0] DEFAULT_LEN = CFG_W'(1000);

  // register indexes
  localparam logic [1:0] REG_MODE = 2'd0;
  localparam logic [1:0] REG_LEN  = 2'd1;
  localparam logic [1:0] REG_STEP = 2'd2;
  localparam logic [1:0] REG_GAP  = 2'd3;

  // window modes
  localparam logic [1:0] MODE_TUMBLE  = 2'd0;
  localparam logic [1:0] MODE_SLIDE   = 2'd1;
  localparam logic [1:0] MODE_SESSION = 2'd2;
  localparam logic [1:0] MODE_BAD     = 2'd3;

  // result status codes
  localparam logic [1:0] ST_WINDOW = 2'd0;
  localparam logic [1:0] ST_NONE   = 2'd1;
  localparam logic [1:0] ST_STORED = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_NEXT = 1'b1;

  typedef struct packed {
    logic                 cmd;
    logic [TIME_BITS-1:0] timestamp;
  } in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [WIN_W-1:0] span_start;
    logic [WIN_W-1:0] span_end;
    logic [CNT_W-1:0] record_count;
  } out_t;

  // effective configuration seen by the datapath
  typedef struct packed {
    logic [1:0]       mode;
    logic [CFG_W-1:0] len;
    logic [CFG_W-1:0] step;
    logic [CFG_W-1:0] gap;
  } cfg_t;

  // datapath operations issued by the controller
  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,
    OP_NONE_KEEP,
    OP_NONE_FIN,
    OP_REQ,
    OP_RD_RP,
    OP_RD_IDX,
    OP_RD_LAST,
    OP_DIV_START,
    OP_DIV_STEP,
    OP_T_SET,
    OP_T_EVAL,
    OP_T_END,
    OP_S_INIT,
    OP_S_EVAL,
    OP_S_LAST,
    OP_SE_INIT,
    OP_SE_EVAL,
    OP_SE_END
  } op_t;

  // datapath status toward the controller
  typedef struct packed {
    logic finished;
    logic started;
    logic rp_lt_sc;
    logic idx_lt_sc;
    logic hit;
    logic div_last;
    logic out_busy;
  } stat_t;

endpackage
`default_nettype wire

[hdl/stwc_regs.sv]
// Configuration registers behind the APB-style port.
// Depends on stwc_pkg; hands effective settings to the datapath.
`timescale 1ns / 1ps
`default_nettype none
module stwc_regs (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [stwc_pkg::PADDR_W-1:0] paddr,
  input  wire logic [stwc_pkg::PDATA_W-1:0] pwdata,
  output logic      [stwc_pkg::PDATA_W-1:0] prdata,
  output logic                             pready,
  output stwc_pkg::cfg_t                   cfg
);

  logic [1:0]                 mode_r;
  logic [stwc_pkg::CFG_W-1:0] len_r, step_r, gap_r;
  logic [1:0]                 idx;
  logic                       wr;

  assign pready = 1'b1;
  assign idx    = paddr[4:3];
  assign wr     = psel && penable && pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= stwc_pkg::MODE_TUMBLE;
      len_r  <= stwc_pkg::DEFAULT_LEN;
      step_r <= stwc_pkg::DEFAULT_LEN;
      gap_r  <= stwc_pkg::DEFAULT_LEN;
    end else if (wr) begin
      case (idx)
        stwc_pkg::REG_MODE: mode_r <= pwdata[1:0];
        stwc_pkg::REG_LEN:  len_r  <= pwdata[stwc_pkg::CFG_W-1:0];
        stwc_pkg::REG_STEP: step_r <= pwdata[stwc_pkg::CFG_W-1:0];
        stwc_pkg::REG_GAP:  gap_r  <= pwdata[stwc_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (idx)
      stwc_pkg::REG_MODE: prdata = {{(stwc_pkg::PDATA_W-2){1'b0}}, mode_r};
      stwc_pkg::REG_LEN:  prdata = {{(stwc_pkg::PDATA_W-stwc_pkg::CFG_W){1'b0}}, len_r};
      stwc_pkg::REG_STEP: prdata = {{(stwc_pkg::PDATA_W-stwc_pkg::CFG_W){1'b0}}, step_r};
      stwc_pkg::REG_GAP:  prdata = {{(stwc_pkg::PDATA_W-stwc_pkg::CFG_W){1'b0}}, gap_r};
      default:            prdata = '0;
    endcase
  end

  // zero length means the default; zero step means the length
  always_comb begin
    cfg.mode = mode_r;
    cfg.len  = (len_r == '0) ? stwc_pkg::DEFAULT_LEN : len_r;
    cfg.step = (step_r == '0) ? cfg.len : step_r;
    cfg.gap  = gap_r;
  end

endmodule
`default_nettype wire

[hdl/stwc_ctrl.sv]
// Controller: sequences loads and window requests as datapath operations.
// Depends on stwc_pkg; drives stwc_dp only through op and reads its stat.
`timescale 1ns / 1ps
`default_nettype none
module stwc_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  input  wire logic           in_cmd,
  output logic                in_stall,
  input  wire logic [1:0]     mode,
  input  stwc_pkg::stat_t     stat,
  output stwc_pkg::op_t       op
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_INIT  = 7'b0000010,
    S_DIV   = 7'b0000100,
    S_TSET  = 7'b0001000,
    S_SCAN  = 7'b0010000,
    S_EVAL  = 7'b0100000,
    S_LAST  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_stall = (state_r != S_IDLE) || stat.out_busy;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // next state and operation
  always_comb begin
    state_nxt = state_r;
    op        = stwc_pkg::OP_NOP;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_cmd == stwc_pkg::CMD_LOAD) begin
            op = stwc_pkg::OP_LOAD;
          end else if (stat.finished) begin
            op = stwc_pkg::OP_NONE_KEEP;
          end else if (mode == stwc_pkg::MODE_BAD || !stat.rp_lt_sc) begin
            op = stwc_pkg::OP_NONE_FIN;
          end else begin
            op = stwc_pkg::OP_REQ;
            if (mode == stwc_pkg::MODE_SESSION || !stat.started) state_nxt = S_INIT;
            else                                                  state_nxt = S_SCAN;
          end
        end
      end
      S_INIT: begin
        case (mode)
          stwc_pkg::MODE_TUMBLE: begin
            op = stwc_pkg::OP_DIV_START;
            state_nxt = S_DIV;
          end
          stwc_pkg::MODE_SLIDE: begin
            op = stwc_pkg::OP_S_INIT;
            state_nxt = S_SCAN;
          end
          default: begin
            op = stwc_pkg::OP_SE_INIT;
            state_nxt = S_SCAN;
          end
        endcase
      end
      S_DIV: begin
        op = stwc_pkg::OP_DIV_STEP;
        if (stat.div_last) state_nxt = S_TSET;
      end
      S_TSET: begin
        op = stwc_pkg::OP_T_SET;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        case (mode)
          stwc_pkg::MODE_TUMBLE: begin
            if (stat.rp_lt_sc) begin
              op = stwc_pkg::OP_RD_RP;
              state_nxt = S_EVAL;
            end else begin
              op = stwc_pkg::OP_T_END;
              state_nxt = S_IDLE;
            end
          end
          stwc_pkg::MODE_SLIDE: begin
            if (stat.idx_lt_sc) begin
              op = stwc_pkg::OP_RD_IDX;
              state_nxt = S_EVAL;
            end else begin
              op = stwc_pkg::OP_RD_LAST;
              state_nxt = S_LAST;
            end
          end
          default: begin
            if (stat.rp_lt_sc) begin
              op = stwc_pkg::OP_RD_RP;
              state_nxt = S_EVAL;
            end else begin
              op = stwc_pkg::OP_SE_END;
              state_nxt = S_IDLE;
            end
          end
        endcase
      end
      S_EVAL: begin
        case (mode)
          stwc_pkg::MODE_TUMBLE: begin
            op = stwc_pkg::OP_T_EVAL;
            state_nxt = stat.hit ? S_SCAN : S_IDLE;
          end
          stwc_pkg::MODE_SLIDE: begin
            op = stwc_pkg::OP_S_EVAL;
            state_nxt = S_SCAN;
          end
          default: begin
            op = stwc_pkg::OP_SE_EVAL;
            state_nxt = stat.hit ? S_SCAN : S_IDLE;
          end
        endcase
      end
      S_LAST: begin
        op = stwc_pkg::OP_S_LAST;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

[hdl/stwc_dp.sv]
// Datapath: record store, window state, remainder unit and result register.
// Depends on stwc_pkg; executes operations from stwc_ctrl.
`timescale 1ns / 1ps
`default_nettype none
module stwc_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  stwc_pkg::op_t                      op,
  input  stwc_pkg::cfg_t                     cfg,
  input  wire logic [stwc_pkg::TIME_BITS-1:0] in_ts,
  output stwc_pkg::stat_t                    stat,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output stwc_pkg::out_t                     out_data
);

  localparam int TB = stwc_pkg::TIME_BITS;
  localparam int CW = stwc_pkg::CUR_W;
  localparam int NW = stwc_pkg::CNT_W;
  localparam int FW = stwc_pkg::CFG_W;
  localparam int WW = stwc_pkg::WIN_W;

  // record store
  logic [TB-1:0] mem [stwc_pkg::STORE_DEPTH];
  logic [TB-1:0] rdata_r;
  logic [stwc_pkg::ADDR_W-1:0] raddr;
  logic          we;

  logic [NW-1:0] sc_r, sc_nxt, rp_r, rp_nxt, idx_r, idx_nxt, scnt_r, scnt_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] start_r, start_nxt, end_r, end_nxt;
  logic          started_r, started_nxt, fin_r, fin_nxt;
  logic [TB-1:0] dvd_r, dvd_nxt, ts_r, ts_nxt;
  logic [FW-1:0] rem_r, rem_nxt;
  logic [stwc_pkg::DCNT_W-1:0] dcnt_r, dcnt_nxt;
  logic          ov_r, ov_nxt;
  stwc_pkg::out_t od_r, od_nxt;

  logic [CW-1:0] t, len_x, step_x, gap_x, slid_start, tset_start;
  logic [FW:0]   rem_sh, rem_sub;
  logic          t_lt_end, sess_ok, in_range;

  assign t      = CW'(rdata_r);
  assign len_x  = CW'(cfg.len);
  assign step_x = CW'(cfg.step);
  assign gap_x  = CW'(cfg.gap);

  // record comparisons on the registered read data
  assign t_lt_end   = t < end_r;
  assign sess_ok    = (t <= end_r) || ((t - end_r) <= gap_x);
  assign in_range   = (t >= start_r) && t_lt_end;
  assign slid_start = start_r + step_x;
  assign tset_start = CW'(ts_r) - CW'(rem_r);

  // one restoring remainder step
  assign rem_sh  = {rem_r, dvd_r[TB-1]};
  assign rem_sub = rem_sh - {1'b0, cfg.len};

  always_comb begin
    stat.finished  = fin_r;
    stat.started   = started_r;
    stat.rp_lt_sc  = rp_r < sc_r;
    stat.idx_lt_sc = idx_r < sc_r;
    stat.hit       = (cfg.mode == stwc_pkg::MODE_TUMBLE) ? t_lt_end : sess_ok;
    stat.div_last  = dcnt_r == '0;
    stat.out_busy  = ov_r && out_stall;
  end

  // read address
  always_comb begin
    case (op)
      stwc_pkg::OP_REQ:
        raddr = (cfg.mode == stwc_pkg::MODE_SESSION) ? rp_r[stwc_pkg::ADDR_W-1:0] : '0;
      stwc_pkg::OP_RD_RP:   raddr = rp_r[stwc_pkg::ADDR_W-1:0];
      stwc_pkg::OP_RD_IDX:  raddr = idx_r[stwc_pkg::ADDR_W-1:0];
      stwc_pkg::OP_RD_LAST: raddr = sc_r[stwc_pkg::ADDR_W-1:0] - 1'b1;
      default:              raddr = '0;
    endcase
  end

  assign we = (op == stwc_pkg::OP_LOAD) && (sc_r != NW'(stwc_pkg::STORE_DEPTH));

  always_ff @(posedge clk) begin
    if (we) mem[sc_r[stwc_pkg::ADDR_W-1:0]] <= in_ts;
    rdata_r <= mem[raddr];
  end

  // operation execution
  always_comb begin
    sc_nxt      = sc_r;
    rp_nxt      = rp_r;
    idx_nxt     = idx_r;
    scnt_nxt    = scnt_r;
    cnt_nxt     = cnt_r;
    start_nxt   = start_r;
    end_nxt     = end_r;
    started_nxt = started_r;
    fin_nxt     = fin_r;
    dvd_nxt     = dvd_r;
    ts_nxt      = ts_r;
    rem_nxt     = rem_r;
    dcnt_nxt    = dcnt_r;
    ov_nxt      = ov_r && out_stall;
    od_nxt      = od_r;
    case (op)
      stwc_pkg::OP_LOAD: begin
        ov_nxt = 1'b1;
        od_nxt = '0;
        if (we) begin
          sc_nxt        = sc_r + 1'b1;
          od_nxt.status = stwc_pkg::ST_STORED;
        end else begin
          od_nxt.status = stwc_pkg::ST_FULL;
        end
      end
      stwc_pkg::OP_NONE_KEEP: begin
        ov_nxt        = 1'b1;
        od_nxt        = '0;
        od_nxt.status = stwc_pkg::ST_NONE;
      end
      stwc_pkg::OP_NONE_FIN: begin
        fin_nxt       = 1'b1;
        ov_nxt        = 1'b1;
        od_nxt        = '0;
        od_nxt.status = stwc_pkg::ST_NONE;
      end
      stwc_pkg::OP_REQ: begin
        idx_nxt  = '0;
        scnt_nxt = '0;
      end
      stwc_pkg::OP_DIV_START: begin
        dvd_nxt  = rdata_r;
        ts_nxt   = rdata_r;
        rem_nxt  = '0;
        dcnt_nxt = stwc_pkg::DCNT_W'(TB - 1);
      end
      stwc_pkg::OP_DIV_STEP: begin
        rem_nxt  = rem_sub[FW] ? rem_sh[FW-1:0] : rem_sub[FW-1:0];
        dvd_nxt  = {dvd_r[TB-2:0], 1'b0};
        dcnt_nxt = dcnt_r - 1'b1;
      end
      stwc_pkg::OP_T_SET: begin
        start_nxt   = tset_start;
        end_nxt     = tset_start + len_x;
        cnt_nxt     = '0;
        started_nxt = 1'b1;
      end
      stwc_pkg::OP_T_EVAL: begin
        if (t_lt_end) begin
          cnt_nxt = cnt_r + 1'b1;
          rp_nxt  = rp_r + 1'b1;
        end else begin
          ov_nxt    = 1'b1;
          od_nxt    = {stwc_pkg::ST_WINDOW, start_r[WW-1:0], end_r[WW-1:0], cnt_r};
          start_nxt = end_r;
          end_nxt   = end_r + len_x;
          cnt_nxt   = '0;
        end
      end
      stwc_pkg::OP_T_END: begin
        fin_nxt = 1'b1;
        ov_nxt  = 1'b1;
        if (cnt_r != '0) begin
          od_nxt = {stwc_pkg::ST_WINDOW, start_r[WW-1:0], end_r[WW-1:0], cnt_r};
        end else begin
          od_nxt        = '0;
          od_nxt.status = stwc_pkg::ST_NONE;
        end
      end
      stwc_pkg::OP_S_INIT: begin
        start_nxt   = t;
        end_nxt     = t + len_x;
        started_nxt = 1'b1;
      end
      stwc_pkg::OP_S_EVAL: begin
        if (in_range) scnt_nxt = scnt_r + 1'b1;
        idx_nxt = idx_r + 1'b1;
      end
      stwc_pkg::OP_S_LAST: begin
        ov_nxt    = 1'b1;
        od_nxt    = {stwc_pkg::ST_WINDOW, start_r[WW-1:0], end_r[WW-1:0], scnt_r};
        start_nxt = slid_start;
        end_nxt   = end_r + step_x;
        cnt_nxt   = '0;
        // rdata holds the last stored record here
        if (slid_start >= t) fin_nxt = 1'b1;
      end
      stwc_pkg::OP_SE_INIT: begin
        start_nxt = t;
        end_nxt   = t;
        cnt_nxt   = NW'(1);
        rp_nxt    = rp_r + 1'b1;
      end
      stwc_pkg::OP_SE_EVAL: begin
        if (sess_ok) begin
          end_nxt = t;
          cnt_nxt = cnt_r + 1'b1;
          rp_nxt  = rp_r + 1'b1;
        end else begin
          ov_nxt = 1'b1;
          od_nxt = {stwc_pkg::ST_WINDOW, start_r[WW-1:0], end_r[WW-1:0], cnt_r};
        end
      end
      stwc_pkg::OP_SE_END: begin
        ov_nxt = 1'b1;
        od_nxt = {stwc_pkg::ST_WINDOW, start_r[WW-1:0], end_r[WW-1:0], cnt_r};
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_r      <= '0;
      rp_r      <= '0;
      cnt_r     <= '0;
      start_r   <= '0;
      end_r     <= '0;
      started_r <= 1'b0;
      fin_r     <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      sc_r      <= sc_nxt;
      rp_r      <= rp_nxt;
      cnt_r     <= cnt_nxt;
      start_r   <= start_nxt;
      end_r     <= end_nxt;
      started_r <= started_nxt;
      fin_r     <= fin_nxt;
      ov_r      <= ov_nxt;
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    scnt_r <= scnt_nxt;
    dvd_r  <= dvd_nxt;
    ts_r   <= ts_nxt;
    rem_r  <= rem_nxt;
    dcnt_r <= dcnt_nxt;
    od_r   <= od_nxt;
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

endmodule
`default_nettype wire

[hdl/stream_time_window_counter.sv]
// Stream time window counter: top level joining registers, controller
// and datapath. Depends on stwc_pkg, stwc_regs, stwc_ctrl and stwc_dp.
//
// Usage: the input channel (in_valid/in_stall/in_data) carries load and
// next-window commands; every transfer produces exactly one result on the
// output channel (out_valid/out_stall/out_data), held in a result register.
// A load writes the 1024-entry record store and answers in the next cycle;
// loads can stream at one per cycle while the result register drains.
// A next-window request walks the store, reading then evaluating each
// record visited: tumbling consumes records up to the window edge, sliding
// scans the whole store, session consumes the records of one session. The
// first tumbling request also runs a remainder loop to align the window.
// While a request is in work, or a result waits under stall, in_stall
// stays high. Settings are written through the psel/penable port at byte
// address 8*i; the user must write them only while the block is idle, as
// the block does not enforce it. Reset clears the record count, the window
// state and out_valid; store contents are not cleared, nor need to be.
`timescale 1ns / 1ps
`default_nettype none
module stream_time_window_counter (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  stwc_pkg::in_t                     in_data,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output stwc_pkg::out_t                    out_data,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [stwc_pkg::PADDR_W-1:0] paddr,
  input  wire logic [stwc_pkg::PDATA_W-1:0] pwdata,
  output logic      [stwc_pkg::PDATA_W-1:0] prdata,
  output logic                              pready
);

  stwc_pkg::cfg_t  cfg;
  stwc_pkg::stat_t stat;
  stwc_pkg::op_t   op;

  stwc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  stwc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_data.cmd),
    .in_stall (in_stall),
    .mode     (cfg.mode),
    .stat     (stat),
    .op       (op)
  );

  stwc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op),
    .cfg       (cfg),
    .in_ts     (in_data.timestamp),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

[dv/stwc_checker.sv]
// Checker for the stream time window counter: watches the register port and
// both channels, predicts every result and compares it field by field.
// Depends on stwc_pkg for the payload types, status codes and sizes.
`timescale 1ns / 1ps
module stwc_checker
  import stwc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  in_t                in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  out_t               out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output int                 errors,
  output int                 pending
);

  // shadow of the block state
  logic [TIME_BITS-1:0] rec_mem [STORE_DEPTH];
  int unsigned rec_cnt, rd_pos, win_cnt;
  logic [63:0] win_lo, win_hi;
  bit          win_open, done;

  // shadow of the settings
  logic [1:0]  m_mode;
  logic [63:0] m_len, m_step, m_gap;

  out_t window_q[$];

  function automatic out_t mk(logic [1:0] st, logic [63:0] s, logic [63:0] e,
                              int unsigned c);
    out_t r;
    r.status       = st;
    r.span_start   = s[WIN_W-1:0];
    r.span_end     = e[WIN_W-1:0];
    r.record_count = c[CNT_W-1:0];
    return r;
  endfunction

  task automatic tumble_next(output out_t r);
    logic [63:0] len, s, e;
    int unsigned c;
    len = (m_len == 0) ? 64'd1000 : m_len;
    if (rd_pos >= rec_cnt) begin
      done = 1'b1;
      r = mk(ST_NONE, 0, 0, 0);
      return;
    end
    // first window aligned to a multiple of the length
    if (!win_open) begin
      win_lo = (64'(rec_mem[0]) / len) * len;
      win_hi = win_lo + len;
      win_cnt = 0;
      win_open = 1'b1;
    end
    while (rd_pos < rec_cnt) begin
      if (64'(rec_mem[rd_pos]) < win_hi) begin
        win_cnt++;
        rd_pos++;
      end else begin
        s = win_lo;
        e = win_hi;
        c = win_cnt;
        win_lo = win_hi;
        win_hi = win_hi + len;
        win_cnt = 0;
        r = mk(ST_WINDOW, s, e, c);
        return;
      end
    end
    done = 1'b1;
    if (win_cnt > 0) r = mk(ST_WINDOW, win_lo, win_hi, win_cnt);
    else r = mk(ST_NONE, 0, 0, 0);
  endtask

  task automatic slide_next(output out_t r);
    logic [63:0] len, stp, s, e, t;
    int unsigned c;
    len = (m_len == 0) ? 64'd1000 : m_len;
    stp = (m_step == 0) ? len : m_step;
    c = 0;
    if (rd_pos >= rec_cnt) begin
      done = 1'b1;
      r = mk(ST_NONE, 0, 0, 0);
      return;
    end
    if (!win_open) begin
      win_lo = 64'(rec_mem[0]);
      win_hi = win_lo + len;
      win_open = 1'b1;
    end
    // whole store is scanned for every window
    for (int i = 0; i < rec_cnt; i++) begin
      t = 64'(rec_mem[i]);
      if (t >= win_lo && t < win_hi) c++;
    end
    s = win_lo;
    e = win_hi;
    win_lo = win_lo + stp;
    win_hi = win_hi + stp;
    win_cnt = 0;
    if (win_lo >= 64'(rec_mem[rec_cnt-1])) done = 1'b1;
    r = mk(ST_WINDOW, s, e, c);
  endtask

  task automatic session_next(output out_t r);
    logic [63:0] t;
    if (rd_pos >= rec_cnt) begin
      done = 1'b1;
      r = mk(ST_NONE, 0, 0, 0);
      return;
    end
    win_lo = 64'(rec_mem[rd_pos]);
    win_hi = win_lo;
    win_cnt = 1;
    rd_pos++;
    // earlier records count as inside the gap
    while (rd_pos < rec_cnt) begin
      t = 64'(rec_mem[rd_pos]);
      if (t <= win_hi || t - win_hi <= m_gap) begin
        win_hi = t;
        win_cnt++;
        rd_pos++;
      end else begin
        break;
      end
    end
    r = mk(ST_WINDOW, win_lo, win_hi, win_cnt);
  endtask

  task automatic predict_result(input in_t d, output out_t r);
    if (d.cmd == CMD_LOAD) begin
      if (rec_cnt >= STORE_DEPTH) begin
        r = mk(ST_FULL, 0, 0, 0);
      end else begin
        rec_mem[rec_cnt] = d.timestamp;
        rec_cnt++;
        r = mk(ST_STORED, 0, 0, 0);
      end
    end else if (done) begin
      r = mk(ST_NONE, 0, 0, 0);
    end else begin
      case (m_mode)
        MODE_TUMBLE:  tumble_next(r);
        MODE_SLIDE:   slide_next(r);
        MODE_SESSION: session_next(r);
        default: begin
          done = 1'b1;
          r = mk(ST_NONE, 0, 0, 0);
        end
      endcase
    end
  endtask

  always @(posedge clk) begin
    out_t w, got;
    if (!rst_n) begin
      rec_cnt = 0;
      rd_pos = 0;
      win_cnt = 0;
      win_lo = 0;
      win_hi = 0;
      win_open = 1'b0;
      done = 1'b0;
      m_mode = MODE_TUMBLE;
      m_len = 64'd1000;
      m_step = 64'd1000;
      m_gap = 64'd1000;
      window_q.delete();
      errors = 0;
    end else begin
      // register write
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:3])
          REG_MODE: m_mode = pwdata[1:0];
          REG_LEN:  m_len  = 64'(pwdata[CFG_W-1:0]);
          REG_STEP: m_step = 64'(pwdata[CFG_W-1:0]);
          REG_GAP:  m_gap  = 64'(pwdata[CFG_W-1:0]);
          default: ;
        endcase
      end
      // input transfer
      if (in_valid && !in_stall) begin
        predict_result(in_data, w);
        window_q.push_back(w);
      end
      // result transfer
      if (out_valid && !out_stall) begin
        got = out_data;
        if (window_q.size() == 0) begin
          $error("result with none expected: status %0d", got.status);
          errors++;
        end else begin
          w = window_q.pop_front();
          if (got.status !== w.status) begin
            $error("status: expected %0d, actual %0d", w.status, got.status);
            errors++;
          end
          if (got.span_start !== w.span_start) begin
            $error("span_start: expected %0d, actual %0d", w.span_start,
                   got.span_start);
            errors++;
          end
          if (got.span_end !== w.span_end) begin
            $error("span_end: expected %0d, actual %0d", w.span_end,
                   got.span_end);
            errors++;
          end
          if (got.record_count !== w.record_count) begin
            $error("record_count: expected %0d, actual %0d", w.record_count,
                   got.record_count);
            errors++;
          end
        end
      end
    end
    pending = window_q.size();
  end

endmodule

[dv/tb.sv]
// Testbench top for the stream time window counter: clock, reset, stimulus
// through the register port and the input channel, result-side stalls and
// the verdict. Depends on stwc_pkg, stream_time_window_counter, stwc_checker.
`timescale 1ns / 1ps
module tb;
  import stwc_pkg::*;

  localparam int LIMIT = 2000000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  in_t                in_data;
  logic               out_valid;
  logic               out_stall;
  out_t               out_data;
  logic               psel, penable, pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int errors, pending;
  int hold_cycles = 0;
  int cycles = 0;
  bit quiet = 1'b0;
  logic [63:0] ts_base;

  stream_time_window_counter u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  stwc_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata), .errors(errors), .pending(pending)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // watchdog
  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // result-side stalls: short runs mostly, a few long, plus a requested hold
  initial begin
    int n, pick;
    out_stall <= 1'b0;
    forever begin
      if (hold_cycles > 0) begin
        n = hold_cycles;
        hold_cycles = 0;
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
          out_stall <= 1'b0;
          repeat ($urandom_range(1, 20)) @(posedge clk);
        end else if (pick < 92) begin
          out_stall <= 1'b1;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end else begin
          out_stall <= 1'b1;
          repeat ($urandom_range(10, 60)) @(posedge clk);
        end
      end
    end
  end

  function automatic logic [TIME_BITS-1:0] rnd_ts();
    return TIME_BITS'({$urandom, $urandom});
  endfunction

  function automatic logic [CFG_W-1:0] rnd_cfg(int unsigned lo, int unsigned hi);
    return CFG_W'($urandom_range(lo, hi));
  endfunction

  // one transfer on the input channel, then a random gap unless quiet
  task automatic send_item(input logic c, input logic [TIME_BITS-1:0] ts);
    bit st;
    int g, r;
    in_valid <= 1'b1;
    in_data  <= {c, ts};
    forever begin
      @(negedge clk);
      st = in_stall;
      @(posedge clk);
      if (!st) break;
    end
    r = $urandom_range(0, 99);
    g = quiet ? 0 : (r < 65) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    if (g > 0) begin
      in_valid <= 1'b0;
      in_data  <= {1'($urandom_range(0, 1)), rnd_ts()};
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic load_rec(input logic [63:0] ts);
    send_item(CMD_LOAD, ts[TIME_BITS-1:0]);
  endtask

  task automatic next_win();
    send_item(CMD_NEXT, rnd_ts());
  endtask

  // next record time: non-decreasing, with steps up to the given spread
  task automatic load_ordered(input int unsigned spread);
    ts_base = ts_base + $urandom_range(0, spread);
    load_rec(ts_base);
  endtask

  // sender waits until every result has come back
  task automatic drain();
    in_valid <= 1'b0;
    forever begin
      @(negedge clk);
      if (pending == 0) break;
    end
    @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [CFG_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= PDATA_W'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [TIME_BITS-1:0] ts_max;
    int k;
    ts_max = '1;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: tumbling with default length, equal and out-of-order
    // records, window edges, and a far record that keeps windows coming
    quiet = 1'b1;
    load_rec(5);
    load_rec(5);
    load_rec(999);
    load_rec(1000);
    load_rec(1999);
    load_rec(2500);
    load_rec(7000);
    load_rec(6000);
    load_rec(64'(ts_max));
    quiet = 1'b0;
    repeat (8) next_win();
    drain();
    cfg_write(REG_LEN, CFG_W'(1));
    repeat (4) next_win();
    drain();

    // tumbling, random length: walks empty gap windows
    cfg_write(REG_LEN, rnd_cfg(1, 5000));
    ts_base = 8000;
    for (k = 0; k < 80; k++) begin
      if ($urandom_range(0, 99) < 60) next_win();
      else load_ordered(3000);
    end
    drain();

    // sliding, state carried over from tumbling
    cfg_write(REG_MODE, CFG_W'(MODE_SLIDE));
    cfg_write(REG_LEN, rnd_cfg(1, 3000));
    cfg_write(REG_STEP, rnd_cfg(1, 500));
    ts_base = 100000;
    quiet = 1'b1;
    for (k = 0; k < 60; k++) begin
      if ($urandom_range(0, 99) < 40) next_win();
      else load_ordered(400);
    end
    quiet = 1'b0;
    for (k = 0; k < 90; k++) begin
      if ($urandom_range(0, 99) < 40) next_win();
      else load_ordered(400);
    end
    drain();
    cfg_write(REG_LEN, {CFG_W{1'b1}});
    cfg_write(REG_STEP, CFG_W'(1));
    repeat (6) next_win();
    load_ordered(100);
    repeat (4) next_win();
    drain();

    // session, several gap settings; each request follows fresh loads
    cfg_write(REG_MODE, CFG_W'(MODE_SESSION));
    cfg_write(REG_STEP, {CFG_W{1'b1}});
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: cfg_write(REG_GAP, CFG_W'(0));
        1: cfg_write(REG_GAP, rnd_cfg(1, 300));
        2: cfg_write(REG_GAP, {CFG_W{1'b1}});
        default: cfg_write(REG_GAP, rnd_cfg(0, 800));
      endcase
      if (ph == 1) hold_cycles = 400;
      for (k = 0; k < 40; k++) begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 9) == 0) load_rec(64'(rnd_ts()));
          else load_ordered(600);
        end
        next_win();
      end
      drain();
    end

    // invalid mode ends the windows; then fill the store past full
    cfg_write(REG_MODE, CFG_W'(MODE_BAD));
    next_win();
    next_win();
    drain();
    cfg_write(REG_MODE, CFG_W'(MODE_TUMBLE));
    hold_cycles = 300;
    for (k = 0; k < 560; k++) begin
      if ($urandom_range(0, 9) == 0) next_win();
      else load_rec(64'(rnd_ts()));
    end
    load_rec(0);
    load_rec(64'(ts_max));

    drain();
    repeat (50) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
